[design/assert_macros.svh]
// assertion macros for the checker file rfm_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is active
`define RFM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rfm check failed");

// clocked property, checked also during reset
`define RFM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rfm check failed");

`endif

[design/rfm_pkg.sv]
// package: types, codes and constants of the reciprocal frequency meter
`default_nettype none

package rfm_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int CLK_W            = 27;
    localparam int NUM_W            = 34;          // clock_hz * 100
    localparam int KR_W             = 10;          // remainder modulo 1000
    localparam int DIV_CNT_W        = 6;           // holds NUM_W
    localparam int OUT_W            = 24;

    localparam logic [CLK_W-1:0]  CLOCK_RESET = 27'd16000000;
    localparam logic [6:0]        CENTI       = 7'd100;
    localparam logic [NUM_W-1:0]  KHZ_CENTI   = 34'd100000;
    localparam logic [KR_W:0]     KILO        = 11'd1000;
    localparam logic [KR_W-1:0]   ROUND_HALF  = 10'd500;
    localparam logic [OUT_W-1:0]  MAX_OUT     = 24'hFFFFFF;
    localparam logic [7:0]        OVF_MAX     = 8'hFF;

    typedef enum logic [1:0] {
        OP_OVF = 2'd0,
        OP_CAP = 2'd1,
        OP_ACK = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] captured_count;
    } t_in_beat;

    typedef struct packed {
        logic [23:0] period_ticks;
        logic [33:0] freq_centihz;
        logic        khz_flag;
        logic [23:0] shown_value;
        logic        period_bad;
    } t_out_beat;

endpackage

`default_nettype wire

[design/reciprocal_frequency_meter_unit.sv]
// top level of the reciprocal frequency meter
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------
//  event   | in        | i_in_valid / o_in_ready    | i_in_data  (t_in_beat)
//  result  | out       | o_out_valid / i_out_ready  | o_out_data (t_out_beat)
//  config  | in        | i_cfg_we (no wait)         | i_cfg_wdata (clock_hz)
//
// overflow, acknowledge, first capture and ignored beats leave the block idle and ready
// a second capture starts the serial divider of rfm_div, which retires one
// quotient bit per cycle over the 34-bit dividend; the result is then formatted
// a bad period skips the divider and goes straight to the format state
// the finished result sits in the output register; if it is still unclaimed,
// the next result waits in the format state with o_in_ready low
// synchronous active-low reset: waiting for the start edge, clock_hz = 16 MHz
`default_nettype none

module reciprocal_frequency_meter_unit #(
    parameter int COUNTER_BITS = rfm_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire rfm_pkg::t_in_beat           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output rfm_pkg::t_out_beat               o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [rfm_pkg::CLK_W-1:0]   i_cfg_wdata
);

    // period: overflow count above the counter bits
    localparam int PW  = COUNTER_BITS + 8;
    localparam int PWE = (PW > rfm_pkg::OUT_W) ? PW : rfm_pkg::OUT_W;

    rfm_pkg::t_state r_state, n_state;

    // measurement state
    logic                        r_await, n_await;
    logic                        r_locked, n_locked;
    logic [15:0]                 r_start, n_start;
    logic [7:0]                  r_ovf, n_ovf;
    logic [rfm_pkg::CLK_W-1:0]   r_clk_hz;

    // result path
    logic                        r_out_valid, n_out_valid;
    rfm_pkg::t_out_beat          r_out_data, n_out_data;
    logic [PW-1:0]               r_period;
    logic                        r_bad;
    logic                        ld_period;
    logic                        ld_bad_val;

    // divider handshake
    logic                        div_start;
    logic                        div_done;
    logic [rfm_pkg::NUM_W-1:0]   div_num;
    logic [rfm_pkg::NUM_W-1:0]   div_quo;
    logic [PW-1:0]               div_rem;
    logic [rfm_pkg::NUM_W-1:0]   div_kquo;
    logic [rfm_pkg::KR_W-1:0]    div_krem;

    // capture arithmetic
    logic                        in_beat;
    logic [PW-1:0]               cap_m;
    logic [PW-1:0]               base;
    logic [PW:0]                 diff;
    logic                        per_bad;

    // formatting
    logic                        khz;
    logic                        half_up;
    logic                        kround;
    logic [rfm_pkg::NUM_W:0]     shown_raw;
    logic [PWE-1:0]              per_ext;
    logic                        out_free;

    assign in_beat = i_in_valid && o_in_ready;

    // capture masked to the counter width, then the tick span from the start
    assign cap_m   = PW'(i_in_data.captured_count) & ({PW{1'b1}} >> 8);
    assign base    = {r_ovf, {COUNTER_BITS{1'b0}}} + cap_m;
    assign diff    = {1'b0, base} - {1'b0, PW'(r_start)};
    assign per_bad = diff[PW] || (diff == '0);

    // clock_hz * 100 is the dividend
    assign div_num = rfm_pkg::NUM_W'(r_clk_hz) * rfm_pkg::NUM_W'(rfm_pkg::CENTI);

    // khz: clock > 1000 * period, i.e. quotient over 100000 or equal with remainder
    assign khz     = (div_quo > rfm_pkg::KHZ_CENTI) ||
                     ((div_quo == rfm_pkg::KHZ_CENTI) && (div_rem != '0));
    assign half_up = ({div_rem, 1'b0} >= {1'b0, r_period});
    // rounding by 1000 of the quotient is the same as rounding clock / (10 * period)
    assign kround  = (div_krem >= rfm_pkg::ROUND_HALF);
    assign shown_raw = khz
        ? ({1'b0, div_kquo} + (rfm_pkg::NUM_W + 1)'(kround))
        : ({1'b0, div_quo} + (rfm_pkg::NUM_W + 1)'(half_up));
    assign per_ext  = PWE'(r_period);
    assign out_free = !r_out_valid || i_out_ready;

    rfm_div #(
        .PW (PW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (diff[PW-1:0]),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem),
        .o_kquo  (div_kquo),
        .o_krem  (div_krem)
    );

    always_comb begin
        n_state     = r_state;
        n_await     = r_await;
        n_locked    = r_locked;
        n_start     = r_start;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        div_start   = 1'b0;
        ld_period   = 1'b0;
        ld_bad_val  = 1'b0;
        o_in_ready  = 1'b0;

        // result register drains independently of the event side
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            rfm_pkg::ST_IDLE: begin
                // no beat is taken while reset is held
                o_in_ready = i_rst_n;
                if (in_beat) begin
                    unique case (i_in_data.opcode)
                        rfm_pkg::OP_OVF: begin
                            // saturating overflow count, also while locked
                            if (r_ovf != rfm_pkg::OVF_MAX) begin
                                n_ovf = r_ovf + 8'd1;
                            end
                        end
                        rfm_pkg::OP_ACK: begin
                            n_locked = 1'b0;
                        end
                        rfm_pkg::OP_CAP: begin
                            if (!r_locked) begin
                                if (r_await) begin
                                    // start edge
                                    n_start = cap_m[15:0];
                                    n_ovf   = '0;
                                    n_await = 1'b0;
                                end else begin
                                    // end edge: measure and lock
                                    n_await    = 1'b1;
                                    n_locked   = 1'b1;
                                    ld_period  = 1'b1;
                                    ld_bad_val = per_bad;
                                    if (per_bad) begin
                                        n_state = rfm_pkg::ST_FIN;
                                    end else begin
                                        div_start = 1'b1;
                                        n_state   = rfm_pkg::ST_DIV;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rfm_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = rfm_pkg::ST_FIN;
                end
            end
            rfm_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = rfm_pkg::ST_IDLE;
                    if (r_bad) begin
                        n_out_data            = '0;
                        n_out_data.period_bad = 1'b1;
                    end else begin
                        n_out_data.period_ticks =
                            (per_ext > PWE'(rfm_pkg::MAX_OUT)) ? rfm_pkg::MAX_OUT
                                                               : per_ext[rfm_pkg::OUT_W-1:0];
                        n_out_data.freq_centihz = div_quo;
                        n_out_data.khz_flag     = khz;
                        n_out_data.shown_value  =
                            (shown_raw > (rfm_pkg::NUM_W + 1)'(rfm_pkg::MAX_OUT))
                                ? rfm_pkg::MAX_OUT
                                : shown_raw[rfm_pkg::OUT_W-1:0];
                        n_out_data.period_bad   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = rfm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rfm_pkg::ST_IDLE;
            r_await     <= 1'b1;
            r_locked    <= 1'b0;
            r_start     <= '0;
            r_ovf       <= '0;
            r_out_valid <= 1'b0;
            r_clk_hz    <= rfm_pkg::CLOCK_RESET;
        end else begin
            r_state     <= n_state;
            r_await     <= n_await;
            r_locked    <= n_locked;
            r_start     <= n_start;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_clk_hz <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (ld_period) begin
            r_period <= diff[PW-1:0];
            r_bad    <= ld_bad_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

[design/rfm_div.sv]
// bit-serial restoring divider with a chained serial divide-by-1000 of the quotient
`default_nettype none

module rfm_div #(
    parameter int PW = rfm_pkg::COUNTER_BITS_DEF + 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rfm_pkg::NUM_W-1:0]   i_num,
    input  wire logic [PW-1:0]               i_den,
    output logic                             o_done,
    output logic [rfm_pkg::NUM_W-1:0]        o_quo,
    output logic [PW-1:0]                    o_rem,
    output logic [rfm_pkg::NUM_W-1:0]        o_kquo,
    output logic [rfm_pkg::KR_W-1:0]         o_krem
);

    logic [rfm_pkg::NUM_W-1:0]     r_num, n_num;
    logic [PW-1:0]                 r_den;
    logic [PW-1:0]                 r_rem, n_rem;
    logic [rfm_pkg::NUM_W-1:0]     r_quo, n_quo;
    logic [rfm_pkg::NUM_W-1:0]     r_kquo, n_kquo;
    logic [rfm_pkg::KR_W-1:0]      r_krem, n_krem;
    logic [rfm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [PW:0]               rem_sh, rem_sub;
    logic                      qbit;
    logic [rfm_pkg::KR_W:0]    k_sh, k_sub;
    logic                      kbit;

    // one quotient bit per cycle, fed straight into the by-1000 stage
    always_comb begin
        rem_sh  = {r_rem, r_num[rfm_pkg::NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        qbit    = (rem_sh >= {1'b0, r_den});
        n_rem   = qbit ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
        n_num   = {r_num[rfm_pkg::NUM_W-2:0], 1'b0};
        n_quo   = {r_quo[rfm_pkg::NUM_W-2:0], qbit};
        k_sh    = {r_krem, qbit};
        k_sub   = k_sh - rfm_pkg::KILO;
        kbit    = (k_sh >= rfm_pkg::KILO);
        n_krem  = kbit ? k_sub[rfm_pkg::KR_W-1:0] : k_sh[rfm_pkg::KR_W-1:0];
        n_kquo  = {r_kquo[rfm_pkg::NUM_W-2:0], kbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == rfm_pkg::DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= rfm_pkg::DIV_CNT_W'(rfm_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt  <= r_cnt - rfm_pkg::DIV_CNT_W'(1);
                r_busy <= (r_cnt != rfm_pkg::DIV_CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= '0;
            r_kquo <= '0;
            r_krem <= '0;
        end else if (r_busy) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_kquo <= n_kquo;
            r_krem <= n_krem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_kquo = r_kquo;
    assign o_krem = r_krem;

endmodule

`default_nettype wire

[design/rfm_chk.sv]
// port-level checker for the reciprocal frequency meter, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module rfm_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire rfm_pkg::t_out_beat          o_out_data
);

    logic        fields_zero;
    logic        khz_ok;
    logic        hz_reading;
    logic [33:0] shown_ext;
    logic        hz_close;

    assign fields_zero = (o_out_data.period_ticks == '0) && (o_out_data.freq_centihz == '0) &&
                         !o_out_data.khz_flag && (o_out_data.shown_value == '0);
    assign khz_ok      = (o_out_data.freq_centihz >= rfm_pkg::KHZ_CENTI);
    assign hz_reading  = !o_out_data.khz_flag && !o_out_data.period_bad;
    assign shown_ext   = 34'(o_out_data.shown_value);
    assign hz_close    = (shown_ext == o_out_data.freq_centihz) ||
                         (shown_ext == o_out_data.freq_centihz + 34'd1);

    // an unclaimed result beat stays up
    `RFM_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)

    // a bad period clears every numeric field
    `RFM_ASSERT(a_bad_zero, i_clk, i_rst_n, o_out_valid && o_out_data.period_bad |-> fields_zero)

    // kilohertz display only at or above 100000 centihertz
    `RFM_ASSERT(a_khz_freq, i_clk, i_rst_n, o_out_valid && o_out_data.khz_flag |-> khz_ok)

    // hertz display is the truncated frequency, possibly rounded up by one
    `RFM_ASSERT(a_hz_round, i_clk, i_rst_n, o_out_valid && hz_reading |-> hz_close)

    // a good result never reports a zero period
    `RFM_ASSERT(a_good_period, i_clk, i_rst_n, o_out_valid && !o_out_data.period_bad |-> o_out_data.period_ticks != '0)

endmodule

bind reciprocal_frequency_meter_unit rfm_chk u_rfm_chk (.*);

`default_nettype wire

[sim/reciprocal_frequency_meter_unit_test.sv]
`timescale 1ns / 1ps
// self-checking testbench of the reciprocal frequency meter unit
module reciprocal_frequency_meter_unit_test;

    // opcode the block must drop without effect
    localparam logic [1:0] OP_SPARE     = 2'd3;
    // second capture runs the 34-bit serial divide, so quiet well beyond that
    localparam int         QUIET_CYCLES = 80;
    localparam int         STALL_LIMIT  = 4000;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_BURSTY
    } t_rx_mode;

    // clock and stimulus side, all known from time zero
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      ev_valid  = 1'b0;
    rfm_pkg::t_in_beat         ev_data   = '0;
    logic                      res_ready = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [rfm_pkg::CLK_W-1:0] cfg_wdata = '0;
    wire                       ev_ready;
    wire                       res_valid;
    rfm_pkg::t_out_beat        res_data;

    // predicted meter state, mirrors the block after reset
    logic                      m_awaiting_first = 1'b1;
    logic [15:0]               m_start          = '0;
    logic [7:0]                m_ovf            = '0;
    logic                      m_locked         = 1'b0;
    logic [rfm_pkg::CLK_W-1:0] m_clock_hz       = rfm_pkg::CLOCK_RESET;

    // readings predicted but not yet seen on the result channel
    rfm_pkg::t_out_beat        pending_readings[$];

    int               err_count   = 0;
    int               beats_sent  = 0;
    int               idle_cycles = 0;
    int               burst_left  = 0;

    reciprocal_frequency_meter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (ev_valid),
        .o_in_ready  (ev_ready),
        .i_in_data   (ev_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // 4 ns period
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [23:0] clip24(input longint unsigned v);
        return (v > 64'(rfm_pkg::MAX_OUT)) ? rfm_pkg::MAX_OUT : v[23:0];
    endfunction

    // advance the predicted meter by one accepted event beat
    function automatic void measure_event(input rfm_pkg::t_in_beat b);
        longint unsigned    base;
        longint unsigned    period;
        longint unsigned    clk_val;
        longint unsigned    shown;
        rfm_pkg::t_out_beat r;
        if (b.opcode == rfm_pkg::OP_OVF) begin
            // overflow count saturates, counted in every state
            if (m_ovf != rfm_pkg::OVF_MAX) m_ovf = m_ovf + 8'd1;
        end else if (b.opcode == rfm_pkg::OP_ACK) begin
            // rearm only, edge pairing untouched
            m_locked = 1'b0;
        end else if (b.opcode == rfm_pkg::OP_CAP && !m_locked) begin
            if (m_awaiting_first) begin
                m_start          = b.captured_count;
                m_ovf            = '0;
                m_awaiting_first = 1'b0;
            end else begin
                m_awaiting_first = 1'b1;
                m_locked         = 1'b1;
                r                = '0;
                base             = 64'(m_ovf) * 65536 + 64'(b.captured_count);
                if (base <= 64'(m_start)) begin
                    // zero or negative period: everything cleared, error raised
                    r.period_bad = 1'b1;
                end else begin
                    period     = base - 64'(m_start);
                    clk_val    = 64'(m_clock_hz);
                    r.khz_flag = (clk_val > 1000 * period);
                    // round to nearest, ties up
                    if (r.khz_flag)
                        shown = (2 * clk_val + 10 * period) / (20 * period);
                    else
                        shown = (200 * clk_val + period) / (2 * period);
                    r.period_ticks = clip24(period);
                    r.freq_centihz = 34'((clk_val * 100) / period);
                    r.shown_value  = clip24(shown);
                end
                pending_readings.push_back(r);
            end
        end
        // captures while locked and the spare opcode fall through
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("error at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        err_count++;
    endtask

    // predictor runs on every accepted event beat
    always @(posedge clk) begin
        if (rst_n && ev_valid && ev_ready) measure_event(ev_data);
    end

    // each result beat against the oldest pending reading, field by field
    always @(posedge clk) begin : check_reading
        rfm_pkg::t_out_beat want;
        if (rst_n && res_valid && res_ready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("reading with none pending", 64'd0, 64'd0);
            end else begin
                want = pending_readings.pop_front();
                if (res_data.period_ticks !== want.period_ticks)
                    report_mismatch("period_ticks", want.period_ticks, res_data.period_ticks);
                if (res_data.freq_centihz !== want.freq_centihz)
                    report_mismatch("freq_centihz", want.freq_centihz, res_data.freq_centihz);
                if (res_data.khz_flag !== want.khz_flag)
                    report_mismatch("khz_flag", want.khz_flag, res_data.khz_flag);
                if (res_data.shown_value !== want.shown_value)
                    report_mismatch("shown_value", want.shown_value, res_data.shown_value);
                if (res_data.period_bad !== want.period_bad)
                    report_mismatch("period_bad", want.period_bad, res_data.period_bad);
            end
        end
    end

    // watchdog: too long without a beat on either channel ends the run
    always @(posedge clk) begin
        if ((ev_valid && ev_ready) || (res_valid && res_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("reciprocal_frequency_meter_unit: mismatch");
            $finish;
        end
    end

    // result side back-pressure, switching between its own patterns
    t_rx_mode rx_mode      = RX_ALWAYS;
    int       rx_mode_left = 0;
    int       rx_hold      = 0;

    always @(negedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(50, 300);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_ALWAYS: begin
                res_ready <= 1'b1;
            end
            RX_RANDOM: begin
                res_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                // long stalls, short open windows
                if (rx_hold > 0) begin
                    rx_hold--;
                end else begin
                    rx_hold = res_ready ? $urandom_range(1, 20) : $urandom_range(1, 8);
                    res_ready <= !res_ready;
                end
            end
        endcase
    end

    // one event beat, with bursts and random gaps on the sending side
    task automatic send_beat(input logic [1:0] op, input logic [15:0] count);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(7, 45);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0) begin
                @(negedge clk);
                ev_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        ev_valid <= 1'b1;
        ev_data  <= rfm_pkg::t_in_beat'({op, count});
        @(posedge clk);
        while (!ev_ready) @(posedge clk);
        beats_sent++;
    endtask

    // hold off until every reading is in and the divider has surely settled
    task automatic wait_for_quiet();
        @(negedge clk);
        ev_valid  <= 1'b0;
        burst_left = 0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_clock(input logic [rfm_pkg::CLK_W-1:0] hz);
        wait_for_quiet();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= hz;
        @(negedge clk);
        cfg_we    <= 1'b0;
        m_clock_hz = hz;
    endtask

    // start edge, overflows, end edge, then optional rearm
    task automatic measure_once(input logic [15:0] start, input int ovfs,
                                input logic [15:0] stop, input bit rearm);
        send_beat(rfm_pkg::OP_CAP, start);
        repeat (ovfs) send_beat(rfm_pkg::OP_OVF, 16'($urandom));
        send_beat(rfm_pkg::OP_CAP, stop);
        if (rearm) send_beat(rfm_pkg::OP_ACK, 16'($urandom));
    endtask

    task automatic test_reset_clock();
        // 16 MHz after reset, 1000 ticks gives 16 kHz
        measure_once(16'd100, 0, 16'd1100, 1'b1);
    endtask

    task automatic test_directed_cases();
        send_beat(rfm_pkg::OP_ACK, 16'h0000);
        send_beat(OP_SPARE, 16'hFFFF);
        measure_once(16'h0000, 0, 16'hFFFF, 1'b1);
        // zero period
        measure_once(16'hFFFF, 0, 16'hFFFF, 1'b1);
        // negative period
        measure_once(16'hFFFF, 0, 16'h0000, 1'b1);
        // wrap through one overflow, then captures while locked are dropped
        send_beat(rfm_pkg::OP_CAP, 16'd100);
        send_beat(rfm_pkg::OP_OVF, 16'h0000);
        send_beat(rfm_pkg::OP_CAP, 16'd50);
        send_beat(rfm_pkg::OP_CAP, 16'd7);
        send_beat(rfm_pkg::OP_OVF, 16'h1234);
        send_beat(OP_SPARE, 16'h0000);
        send_beat(rfm_pkg::OP_ACK, 16'hFFFF);
        // acknowledge between the start and end edges leaves the pairing alone
        send_beat(rfm_pkg::OP_CAP, 16'h5555);
        send_beat(rfm_pkg::OP_ACK, 16'h0000);
        send_beat(rfm_pkg::OP_OVF, 16'h0000);
        send_beat(rfm_pkg::OP_CAP, 16'hAAAA);
        send_beat(rfm_pkg::OP_ACK, 16'h0000);
    endtask

    task automatic test_khz_boundary();
        // exactly 1000 Hz stays in hertz, one more switches to kilohertz
        set_clock(27'd1000);
        measure_once(16'd0, 0, 16'd1, 1'b1);
        set_clock(27'd1001);
        measure_once(16'd10, 0, 16'd11, 1'b1);
        set_clock(rfm_pkg::CLOCK_RESET);
        measure_once(16'd0, 0, 16'd16000, 1'b1);
        measure_once(16'd0, 0, 16'd15999, 1'b1);
    endtask

    task automatic test_rounding_ties();
        // 12.5 centihertz rounds up, likewise 100.5 in units of 10 Hz
        set_clock(27'd1);
        measure_once(16'd0, 0, 16'd8, 1'b1);
        set_clock(27'd1005);
        measure_once(16'd0, 0, 16'd1, 1'b1);
    endtask

    task automatic test_overflow_saturation();
        // overflow count pins at its top, giving the longest period
        set_clock(rfm_pkg::CLOCK_RESET);
        measure_once(16'h0000, 300, 16'hFFFF, 1'b0);
        // locked: overflows still counted, the capture dropped
        send_beat(rfm_pkg::OP_OVF, 16'h0000);
        send_beat(rfm_pkg::OP_CAP, 16'h0001);
        send_beat(rfm_pkg::OP_ACK, 16'h0000);
    endtask

    task automatic run_random_traffic(input int n_beats);
        int          target;
        int          kind;
        int          ovfs;
        logic [15:0] start;
        logic [15:0] stop;
        target = beats_sent + n_beats;
        while (beats_sent < target) begin
            kind  = $urandom_range(0, 9);
            start = 16'($urandom);
            if (kind <= 6) begin
                // well-formed measurement with random content
                ovfs = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 20)
                                                   : $urandom_range(0, 2);
                case ($urandom_range(0, 2))
                    0:       stop = start + 16'($urandom_range(1, 64));
                    1:       stop = start + 16'($urandom_range(0, 4)) - 16'd2;
                    default: stop = 16'($urandom);
                endcase
                if ($urandom_range(0, 3) == 0) send_beat(rfm_pkg::OP_ACK, 16'($urandom));
                measure_once(start, ovfs, stop, $urandom_range(0, 5) != 0);
            end else if (kind <= 8) begin
                // noise beats of any opcode
                repeat ($urandom_range(1, 4))
                    send_beat(2'($urandom_range(0, 3)), 16'($urandom));
            end else begin
                // pair then an extra capture that hits the lock
                send_beat(rfm_pkg::OP_CAP, start);
                send_beat(rfm_pkg::OP_CAP, 16'($urandom));
                send_beat(rfm_pkg::OP_CAP, 16'($urandom));
                send_beat(rfm_pkg::OP_ACK, 16'($urandom));
            end
        end
    endtask

    task automatic test_clock_sweep();
        logic [rfm_pkg::CLK_W-1:0] sweep[6];
        sweep = '{27'd100000000, 27'd0, 27'h7FFFFFF, 27'd1,
                  27'($urandom_range(1, 100000000)), 27'($urandom_range(1, 100000000))};
        foreach (sweep[k]) begin
            set_clock(sweep[k]);
            run_random_traffic(100);
        end
    endtask

    initial begin
        // synchronous reset held from time zero, released on a falling edge
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_clock();
        test_directed_cases();
        test_khz_boundary();
        test_rounding_ties();
        test_overflow_saturation();
        test_clock_sweep();
        wait_for_quiet();
        if (err_count == 0)
            $display("reciprocal_frequency_meter_unit: match");
        else
            $display("reciprocal_frequency_meter_unit: mismatch");
        $finish;
    end

endmodule
